// ===== src/piaim_pkg.sv =====
package piaim_pkg;

	// Field and intermediate widths. Every bound below follows from the 24-bit
	// coordinates and the 23-bit speed.
	localparam int CW     = 24;  // coordinate and velocity
	localparam int SW     = 23;  // shot speed
	localparam int PW     = 50;  // signed dot product d.v
	localparam int AW     = 49;  // magnitude of d.v
	localparam int D2W    = 49;  // |d|^2
	localparam int V2W    = 48;  // |v|^2
	localparam int MW     = 46;  // s^2 - |v|^2
	localparam int DW     = 98;  // discriminant
	localparam int RW     = 49;  // square root
	localparam int NUMW   = 50;  // d.v + root
	localparam int NW     = 74;  // |v component| * numerator
	localparam int QW     = 41;  // quotient bits kept
	localparam int OW     = 42;  // signed lead point before the clamp
	localparam int CFG_IW = 3;   // configuration index

	localparam logic [QW-1:0] OFFSET_CAP = 41'h100_0000_0000;

	typedef enum logic [CFG_IW-1:0] {
		REG_BOUND_LEFT   = 3'd0,
		REG_BOUND_TOP    = 3'd1,
		REG_BOUND_RIGHT  = 3'd2,
		REG_BOUND_BOTTOM = 3'd3
	} cfg_reg_t;

	// Data that rides along the square root pipeline.
	typedef struct packed {
		logic                 lead_ok;
		logic signed [CW-1:0] tx;
		logic signed [CW-1:0] ty;
		logic signed [CW-1:0] vx;
		logic signed [CW-1:0] vy;
		logic signed [PW-1:0] p;
		logic [MW-1:0]        m;
	} sq_side_t;

	// Data that rides along the divider pipeline.
	typedef struct packed {
		logic                 lead_ok;
		logic signed [CW-1:0] tx;
		logic signed [CW-1:0] ty;
		logic                 neg_x;
		logic                 neg_y;
	} dv_side_t;

endpackage

// ===== src/piaim_front.sv =====
module piaim_front
	import piaim_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [CW-1:0] shooter_x,
	input  logic signed [CW-1:0] shooter_y,
	input  logic [SW-1:0]        shot_speed,
	input  logic signed [CW-1:0] target_x,
	input  logic signed [CW-1:0] target_y,
	input  logic signed [CW-1:0] target_vx,
	input  logic signed [CW-1:0] target_vy,
	output logic                 out_valid,
	output sq_side_t             out_side,
	output logic [DW-1:0]        out_disc
);

	localparam int AL = 25;  // low slice of |d.v|
	localparam int ML = 23;  // low slice of m
	localparam int EL = 25;  // low slice of |d|^2

	logic                   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic signed [CW:0]     dx_s1, dy_s1;
	logic signed [CW-1:0]   vx_s1, vy_s1, tx_s1, ty_s1;
	logic [SW-1:0]          spd_s1;
	logic signed [2*CW:0]   dvx_s2, dvy_s2;
	logic signed [2*CW+1:0] dxx_s2, dyy_s2;
	logic signed [2*CW-1:0] vxx_s2, vyy_s2;
	logic [2*SW-1:0]        ss_s2, ss_s3;
	logic signed [CW-1:0]   vx_s2, vy_s2, tx_s2, ty_s2;
	logic signed [CW-1:0]   vx_s3, vy_s3, tx_s3, ty_s3;
	logic signed [PW-1:0]   p_s3;
	logic [D2W-1:0]         d2_s3, d2_s4;
	logic [V2W-1:0]         v2_s3;
	logic [AW-1:0]          am_s4;
	sq_side_t               side_s4, side_s5, side_s6, side_s7;
	logic [2*(AW-AL)-1:0]   pp_aa_s5;
	logic [AW-1:0]          pp_ab_s5;
	logic [2*AL-1:0]        pp_bb_s5;
	logic [MW+D2W-ML-EL-1:0] pm11_s5;
	logic [MW-ML+EL-1:0]    pm10_s5;
	logic [ML+D2W-EL-1:0]   pm01_s5;
	logic [ML+EL-1:0]       pm00_s5;
	logic [DW-1:0]          psq_s6, md_s6, disc_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= {target_x[CW-1], target_x} - {shooter_x[CW-1], shooter_x};
			dy_s1  <= {target_y[CW-1], target_y} - {shooter_y[CW-1], shooter_y};
			vx_s1  <= target_vx;
			vy_s1  <= target_vy;
			tx_s1  <= target_x;
			ty_s1  <= target_y;
			spd_s1 <= shot_speed;

			dvx_s2 <= dx_s1 * vx_s1;
			dvy_s2 <= dy_s1 * vy_s1;
			dxx_s2 <= dx_s1 * dx_s1;
			dyy_s2 <= dy_s1 * dy_s1;
			vxx_s2 <= vx_s1 * vx_s1;
			vyy_s2 <= vy_s1 * vy_s1;
			ss_s2  <= spd_s1 * spd_s1;
			vx_s2  <= vx_s1;
			vy_s2  <= vy_s1;
			tx_s2  <= tx_s1;
			ty_s2  <= ty_s1;

			p_s3  <= dvx_s2 + dvy_s2;
			d2_s3 <= D2W'(dxx_s2 + dyy_s2);
			v2_s3 <= V2W'(vxx_s2 + vyy_s2);
			ss_s3 <= ss_s2;
			vx_s3 <= vx_s2;
			vy_s3 <= vy_s2;
			tx_s3 <= tx_s2;
			ty_s3 <= ty_s2;

			// A moving target slower than the shot is the only solvable case.
			side_s4.lead_ok <= (v2_s3 != '0) && (v2_s3 < V2W'(ss_s3));
			side_s4.m       <= ss_s3 - MW'(v2_s3);
			side_s4.p       <= p_s3;
			side_s4.tx      <= tx_s3;
			side_s4.ty      <= ty_s3;
			side_s4.vx      <= vx_s3;
			side_s4.vy      <= vy_s3;
			am_s4           <= p_s3[PW-1] ? AW'(-p_s3) : AW'(p_s3);
			d2_s4           <= d2_s3;

			pp_aa_s5 <= am_s4[AW-1:AL] * am_s4[AW-1:AL];
			pp_ab_s5 <= am_s4[AW-1:AL] * am_s4[AL-1:0];
			pp_bb_s5 <= am_s4[AL-1:0] * am_s4[AL-1:0];
			pm11_s5  <= side_s4.m[MW-1:ML] * d2_s4[D2W-1:EL];
			pm10_s5  <= side_s4.m[MW-1:ML] * d2_s4[EL-1:0];
			pm01_s5  <= side_s4.m[ML-1:0] * d2_s4[D2W-1:EL];
			pm00_s5  <= side_s4.m[ML-1:0] * d2_s4[EL-1:0];
			side_s5  <= side_s4;

			psq_s6  <= (DW'(pp_aa_s5) << (2*AL)) + (DW'(pp_ab_s5) << (AL+1))
				+ DW'(pp_bb_s5);
			md_s6   <= (DW'(pm11_s5) << (ML+EL)) + (DW'(pm10_s5) << ML)
				+ (DW'(pm01_s5) << EL) + DW'(pm00_s5);
			side_s6 <= side_s5;

			disc_s7 <= psq_s6 + md_s6;
			side_s7 <= side_s6;
		end
	end

	assign out_valid = vld_s7;
	assign out_side  = side_s7;
	assign out_disc  = disc_s7;

endmodule

// ===== src/piaim_sqrt.sv =====
module piaim_sqrt
	import piaim_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  sq_side_t      in_side,
	input  logic [DW-1:0] in_disc,
	output logic          out_valid,
	output sq_side_t      out_side,
	output logic [RW-1:0] out_root
);

	// One result bit per stage, most significant first. The remainder holds
	// the argument minus the square of the partial root.
	logic          vld_s  [1:RW];
	sq_side_t      side_s [1:RW];
	logic [DW-1:0] rem_s  [1:RW];
	logic [RW-1:0] root_s [1:RW];

	for (genvar i = 1; i <= RW; i++) begin : g_step
		localparam int B = RW - i;
		logic          vld_p;
		sq_side_t      side_p;
		logic [DW-1:0] rem_p;
		logic [RW-1:0] root_p;
		logic [DW:0]   trial;
		logic          take;

		if (i == 1) begin : g_first
			assign vld_p  = in_valid;
			assign side_p = in_side;
			assign rem_p  = in_disc;
			assign root_p = '0;
		end else begin : g_next
			assign vld_p  = vld_s[i-1];
			assign side_p = side_s[i-1];
			assign rem_p  = rem_s[i-1];
			assign root_p = root_s[i-1];
		end

		// (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B); the two terms never overlap.
		assign trial = ((DW+1)'(root_p) << (B+1)) | ((DW+1)'(1) << (2*B));
		assign take  = {1'b0, rem_p} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i] <= side_p;
				rem_s[i]  <= take ? DW'({1'b0, rem_p} - trial) : rem_p;
				root_s[i] <= take ? (root_p | (RW'(1) << B)) : root_p;
			end
		end
	end

	assign out_valid = vld_s[RW];
	assign out_side  = side_s[RW];
	assign out_root  = root_s[RW];

endmodule

// ===== src/piaim_div.sv =====
module piaim_div
	import piaim_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  dv_side_t      in_side,
	input  logic [NW-1:0] in_nx,
	input  logic [NW-1:0] in_ny,
	input  logic [MW-1:0] in_m,
	output logic          out_valid,
	output dv_side_t      out_side,
	output logic [QW-1:0] out_qx,
	output logic [QW-1:0] out_qy
);

	// One restoring step: the next dividend bit leaves at the top of nq and a
	// quotient bit enters at its bottom.
	function automatic logic [MW+QW-1:0] div_step(
		input logic [MW-1:0] rem,
		input logic [QW-1:0] nq,
		input logic [MW-1:0] dv
	);
		logic [MW:0] t;
		logic        take;
		t    = {rem, nq[QW-1]};
		take = t >= {1'b0, dv};
		div_step = {(take ? MW'(t - {1'b0, dv}) : MW'(t)), nq[QW-2:0], take};
	endfunction

	logic          vld_s1;
	dv_side_t      side_s1;
	logic [MW-1:0] m_s1, remx_s1, remy_s1;
	logic [QW-1:0] nqx_s1, nqy_s1;
	logic          satx_s1, saty_s1;

	logic          vld_s  [1:QW];
	dv_side_t      side_s [1:QW];
	logic [MW-1:0] m_s    [1:QW];
	logic [MW-1:0] remx_s [1:QW];
	logic [MW-1:0] remy_s [1:QW];
	logic [QW-1:0] nqx_s  [1:QW];
	logic [QW-1:0] nqy_s  [1:QW];
	logic          satx_s [1:QW];
	logic          saty_s [1:QW];

	logic          vld_s2;
	dv_side_t      side_s2;
	logic [QW-1:0] qx_s2, qy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s[QW];
		end
	end

	// A quotient of 2^QW or more is flagged up front; for any other, the high part
	// of the dividend already lies below the divisor.
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_side;
			m_s1    <= in_m;
			satx_s1 <= (MW+QW)'(in_nx) >= ((MW+QW)'(in_m) << QW);
			saty_s1 <= (MW+QW)'(in_ny) >= ((MW+QW)'(in_m) << QW);
			remx_s1 <= MW'(in_nx[NW-1:QW]);
			remy_s1 <= MW'(in_ny[NW-1:QW]);
			nqx_s1  <= in_nx[QW-1:0];
			nqy_s1  <= in_ny[QW-1:0];
		end
	end

	for (genvar i = 1; i <= QW; i++) begin : g_step
		logic          vld_p, satx_p, saty_p;
		dv_side_t      side_p;
		logic [MW-1:0] m_p, remx_p, remy_p;
		logic [QW-1:0] nqx_p, nqy_p;

		if (i == 1) begin : g_first
			assign vld_p  = vld_s1;
			assign side_p = side_s1;
			assign m_p    = m_s1;
			assign remx_p = remx_s1;
			assign remy_p = remy_s1;
			assign nqx_p  = nqx_s1;
			assign nqy_p  = nqy_s1;
			assign satx_p = satx_s1;
			assign saty_p = saty_s1;
		end else begin : g_next
			assign vld_p  = vld_s[i-1];
			assign side_p = side_s[i-1];
			assign m_p    = m_s[i-1];
			assign remx_p = remx_s[i-1];
			assign remy_p = remy_s[i-1];
			assign nqx_p  = nqx_s[i-1];
			assign nqy_p  = nqy_s[i-1];
			assign satx_p = satx_s[i-1];
			assign saty_p = saty_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i]               <= side_p;
				m_s[i]                  <= m_p;
				satx_s[i]               <= satx_p;
				saty_s[i]               <= saty_p;
				{remx_s[i], nqx_s[i]}   <= div_step(remx_p, nqx_p, m_p);
				{remy_s[i], nqy_s[i]}   <= div_step(remy_p, nqy_p, m_p);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s[QW];
			qx_s2   <= (satx_s[QW] || nqx_s[QW] > OFFSET_CAP) ? OFFSET_CAP : nqx_s[QW];
			qy_s2   <= (saty_s[QW] || nqy_s[QW] > OFFSET_CAP) ? OFFSET_CAP : nqy_s[QW];
		end
	end

	assign out_valid = vld_s2;
	assign out_side  = side_s2;
	assign out_qx    = qx_s2;
	assign out_qy    = qy_s2;

endmodule

// ===== src/projectile_intercept_aim_top.sv =====
// Intercept aim point: for each request (shooter origin, shot speed, target
// position and velocity, all Q15.8) the block returns the lead point where a
// straight shot at that speed first meets the target, clamped to the four
// bound registers with the edges included. A target at rest, or one at least
// as fast as the shot, yields the target position unclamped with lead_valid
// low. The design is a single pipeline of 104 register stages, and a new request
// is taken in every cycle while the pipeline is not halted; the depth is set by
// the 49-stage square root (one root bit per stage) and the 43-stage divider (one
// quotient bit per step stage, both coordinates side by side). The whole pipeline
// advances together and halts only while a finished result waits at the output, so
// in_ready is low exactly when out_valid is high and out_ready is low. The bound
// registers take writes in any cycle through the configuration port (index 0
// left, 1 top, 2 right, 3 bottom; other indexes are ignored) and should only be
// changed while no request is in flight.
module projectile_intercept_aim_top
	import piaim_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IW-1:0]        cfg_index,
	input  logic signed [CW-1:0]     cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [CW-1:0]     shooter_x,
	input  logic signed [CW-1:0]     shooter_y,
	input  logic [SW-1:0]            shot_speed,
	input  logic signed [CW-1:0]     target_x,
	input  logic signed [CW-1:0]     target_y,
	input  logic signed [CW-1:0]     target_vx,
	input  logic signed [CW-1:0]     target_vy,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [CW-1:0]     aim_x,
	output logic signed [CW-1:0]     aim_y,
	output logic                     lead_valid
);

	localparam int NL = 25;  // low slice of the numerator

	// Clamp with the low bound checked first, so crossed bounds favor it.
	function automatic logic [CW-1:0] clamp(
		input logic signed [OW-1:0] v,
		input logic signed [CW-1:0] lo,
		input logic signed [CW-1:0] hi
	);
		priority if (v < OW'(lo)) begin
			clamp = lo;
		end else if (v > OW'(hi)) begin
			clamp = hi;
		end else begin
			clamp = v[CW-1:0];
		end
	endfunction

	logic signed [CW-1:0] bound_left_q, bound_top_q, bound_right_q, bound_bottom_q;

	logic          en;
	logic          fr_valid, sq_valid, dv_valid;
	sq_side_t      fr_side, sq_side;
	logic [DW-1:0] fr_disc;
	logic [RW-1:0] sq_root;
	dv_side_t      dv_side;
	logic [QW-1:0] dv_qx, dv_qy;

	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	dv_side_t           side_s1, side_s2, side_s3, side_s4;
	logic [NUMW-1:0]    num_s1;
	logic [CW-1:0]      avx_s1, avy_s1;
	logic [MW-1:0]      m_s1, m_s2, m_s3;
	logic [CW+NUMW-NL-1:0] pxh_s2, pyh_s2;
	logic [CW+NL-1:0]   pxl_s2, pyl_s2;
	logic [NW-1:0]      nx_s3, ny_s3;
	logic signed [OW-1:0] lx_s4, ly_s4;
	logic [CW-1:0]      aim_x_s5, aim_y_s5;
	logic               lead_s5;

	// The pipeline only halts for a result that is not taken.
	assign en        = !vld_s5 || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_left_q   <= '0;
			bound_top_q    <= '0;
			bound_right_q  <= 24'sh7F_FFFF;
			bound_bottom_q <= 24'sh7F_FFFF;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BOUND_LEFT:   bound_left_q   <= cfg_data;
				REG_BOUND_TOP:    bound_top_q    <= cfg_data;
				REG_BOUND_RIGHT:  bound_right_q  <= cfg_data;
				REG_BOUND_BOTTOM: bound_bottom_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Relative position, dot products and the discriminant
	// (d.v)^2 + (s^2 - |v|^2) * |d|^2.
	piaim_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.shooter_x (shooter_x),
		.shooter_y (shooter_y),
		.shot_speed(shot_speed),
		.target_x  (target_x),
		.target_y  (target_y),
		.target_vx (target_vx),
		.target_vy (target_vy),
		.out_valid (fr_valid),
		.out_side  (fr_side),
		.out_disc  (fr_disc)
	);

	piaim_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (fr_valid),
		.in_side  (fr_side),
		.in_disc  (fr_disc),
		.out_valid(sq_valid),
		.out_side (sq_side),
		.out_root (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= sq_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= dv_valid;
			vld_s5 <= vld_s4;
		end
	end

	// The root is never below |d.v|, so the numerator d.v + root is never
	// negative. Each coordinate then needs |v_i| * num / m with the sign of v_i
	// applied afterwards.
	always_ff @(posedge clk) begin
		if (en) begin
			num_s1          <= NUMW'(sq_side.p + $signed({1'b0, sq_root}));
			avx_s1          <= sq_side.vx[CW-1] ? CW'(-sq_side.vx) : CW'(sq_side.vx);
			avy_s1          <= sq_side.vy[CW-1] ? CW'(-sq_side.vy) : CW'(sq_side.vy);
			m_s1            <= sq_side.m;
			side_s1.lead_ok <= sq_side.lead_ok;
			side_s1.tx      <= sq_side.tx;
			side_s1.ty      <= sq_side.ty;
			side_s1.neg_x   <= sq_side.vx[CW-1];
			side_s1.neg_y   <= sq_side.vy[CW-1];

			pxh_s2  <= avx_s1 * num_s1[NUMW-1:NL];
			pxl_s2  <= avx_s1 * num_s1[NL-1:0];
			pyh_s2  <= avy_s1 * num_s1[NUMW-1:NL];
			pyl_s2  <= avy_s1 * num_s1[NL-1:0];
			m_s2    <= m_s1;
			side_s2 <= side_s1;

			nx_s3   <= (NW'(pxh_s2) << NL) + NW'(pxl_s2);
			ny_s3   <= (NW'(pyh_s2) << NL) + NW'(pyl_s2);
			m_s3    <= m_s2;
			side_s3 <= side_s2;
		end
	end

	piaim_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s3),
		.in_side  (side_s3),
		.in_nx    (nx_s3),
		.in_ny    (ny_s3),
		.in_m     (m_s3),
		.out_valid(dv_valid),
		.out_side (dv_side),
		.out_qx   (dv_qx),
		.out_qy   (dv_qy)
	);

	// Lead point, then the clamp in the output register. An unsolved request
	// passes the target position through untouched.
	always_ff @(posedge clk) begin
		if (en) begin
			lx_s4   <= dv_side.neg_x ? OW'(dv_side.tx) - OW'(dv_qx)
				: OW'(dv_side.tx) + OW'(dv_qx);
			ly_s4   <= dv_side.neg_y ? OW'(dv_side.ty) - OW'(dv_qy)
				: OW'(dv_side.ty) + OW'(dv_qy);
			side_s4 <= dv_side;

			aim_x_s5 <= side_s4.lead_ok ? clamp(lx_s4, bound_left_q, bound_right_q)
				: side_s4.tx;
			aim_y_s5 <= side_s4.lead_ok ? clamp(ly_s4, bound_top_q, bound_bottom_q)
				: side_s4.ty;
			lead_s5  <= side_s4.lead_ok;
		end
	end

	assign out_valid  = vld_s5;
	assign aim_x      = aim_x_s5;
	assign aim_y      = aim_y_s5;
	assign lead_valid = lead_s5;

`ifndef SYNTHESIS
	a_clamp_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lead_valid && bound_left_q <= bound_right_q
		|-> aim_x >= bound_left_q && aim_x <= bound_right_q)
		else $error("aim_x outside the x bounds");

	a_clamp_y: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lead_valid && bound_top_q <= bound_bottom_q
		|-> aim_y >= bound_top_q && aim_y <= bound_bottom_q)
		else $error("aim_y outside the y bounds");

	a_root_covers_dot: assert property (@(posedge clk) disable iff (!arst_n)
		sq_valid && sq_side.lead_ok
		|-> $signed({2'b00, sq_root}) >= $signed({sq_side.p[PW-1], sq_side.p})
		&& $signed({2'b00, sq_root}) + $signed({sq_side.p[PW-1], sq_side.p}) >= 0)
		else $error("square root below the magnitude of the dot product");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && side_s3.lead_ok |-> m_s3 != '0)
		else $error("zero divisor on a solvable request");
`endif

endmodule
